/* design/fsra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsra_pkg
// Shared widths, codes and types for the fan speed-range autotuner.
// ----------------------------------------------------------------------------
package fsra_pkg;

	localparam int CNT_W  = 11;              // tach count and running mean
	localparam int NUM_W  = 5;               // sample number / divisor
	localparam int PROD_W = CNT_W + NUM_W;   // mean * (i - 1)
	localparam int STEP_W = 5;               // divider step counter
	localparam int CODE_W = 3;
	localparam int STAT_W = 2;

	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef logic [STAT_W-1:0] stat_t;

	// range codes 0..5 mean 1, 2, 4, 8, 16, 32
	localparam code_t RANGE_1     = 3'd0;
	localparam code_t RANGE_2     = 3'd1;
	localparam code_t RANGE_4     = 3'd2;
	localparam code_t RANGE_8     = 3'd3;
	localparam code_t RANGE_16    = 3'd4;
	localparam code_t RANGE_32    = 3'd5;
	localparam code_t RANGE_RESET = RANGE_4;

	localparam stat_t STAT_RETRY  = 2'd0;
	localparam stat_t STAT_TUNED  = 2'd1;
	localparam stat_t STAT_FAILED = 2'd2;

	localparam count_t MEAN_OVER = 11'd2040;
	localparam count_t MEAN_HIGH = 11'd1000;
	localparam count_t MEAN_X2   = 11'd500;
	localparam count_t MEAN_X4   = 11'd250;
	localparam count_t MEAN_X8   = 11'd125;
	localparam count_t MEAN_X16  = 11'd62;

	typedef struct packed {
		logic                start;
		logic [STEP_W-1:0]   steps;
	} div_ctrl_t;

	typedef struct packed {
		logic                busy;
		logic                done;
	} div_stat_t;

endpackage

/* design/fsra_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsra_div
// Restoring serial divider: one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module fsra_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fsra_pkg::div_ctrl_t   ctrl,
	input  fsra_pkg::prod_t       dividend,
	input  fsra_pkg::num_t        divisor,
	output fsra_pkg::div_stat_t   stat,
	output fsra_pkg::prod_t       quotient
);

	logic [fsra_pkg::STEP_W-1:0] steps_q;
	logic                        busy_q;
	logic                        done_q;
	fsra_pkg::prod_t             work_q;
	fsra_pkg::num_t              rem_q;
	fsra_pkg::num_t              div_q;

	logic [fsra_pkg::NUM_W:0]    trial;
	logic                        ge;
	logic [fsra_pkg::NUM_W:0]    diff;

	always_comb begin
		trial = {rem_q, work_q[fsra_pkg::PROD_W-1]};
		ge    = trial >= {1'b0, div_q};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else if (ctrl.start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			steps_q <= ctrl.steps;
		end else if (busy_q) begin
			steps_q <= steps_q - 1'b1;
			if (steps_q == fsra_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			// shift in the quotient bit where the dividend bit left
			work_q <= {work_q[fsra_pkg::PROD_W-2:0], ge};
			rem_q  <= ge ? diff[fsra_pkg::NUM_W-1:0] : trial[fsra_pkg::NUM_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = work_q;

endmodule

/* design/fsra_rules.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsra_rules
// End-of-round decision: new range code and status from the round mean.
// ----------------------------------------------------------------------------
module fsra_rules (
	input  fsra_pkg::count_t mean,
	input  fsra_pkg::code_t  code_in,
	output fsra_pkg::code_t  code_out,
	output fsra_pkg::stat_t  status
);

	fsra_pkg::code_t code;
	logic            over;

	always_comb begin
		code = (code_in > fsra_pkg::RANGE_32) ? fsra_pkg::RANGE_32 : code_in;
		over = mean > fsra_pkg::MEAN_OVER;
		code_out = code;
		status   = fsra_pkg::STAT_RETRY;
		// first match wins
		if (!over && code == fsra_pkg::RANGE_32) begin
			status = fsra_pkg::STAT_TUNED;
		end else if (!over && mean > fsra_pkg::MEAN_HIGH) begin
			status = fsra_pkg::STAT_TUNED;
		end else if (over && code != fsra_pkg::RANGE_1) begin
			code_out = code - 1'b1;
		end else if (over) begin
			status = fsra_pkg::STAT_FAILED;
		end else if (mean > fsra_pkg::MEAN_X2 && code < fsra_pkg::RANGE_16) begin
			code_out = code + 3'd1;
		end else if (mean > fsra_pkg::MEAN_X4 && code < fsra_pkg::RANGE_8) begin
			code_out = code + 3'd2;
		end else if (mean > fsra_pkg::MEAN_X8 && code < fsra_pkg::RANGE_4) begin
			code_out = code + 3'd3;
		end else if (mean > fsra_pkg::MEAN_X16 && code < fsra_pkg::RANGE_2) begin
			code_out = fsra_pkg::RANGE_16;
		end else begin
			code_out = fsra_pkg::RANGE_32;
		end
	end

endmodule

/* design/fan_speed_range_autotune_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_speed_range_autotune_top
// Per-fan tach speed-range tuner built around one shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one tach sample per transfer, with
//   its fan index and a start flag. in_stall is high whenever a sample is in
//   work; the block takes one sample at a time.
//   Output channel (out_valid / out_stall): one result per finished round of
//   SAMPLES_PER_ROUND samples; other samples produce nothing. The result sits
//   in an output register, so the next sample is taken while it waits.
//   Config channel (cfg_valid / cfg_ready): writes the initial range code
//   (6 and 7 store as 5) into every fan's range. Accepted while idle.
// Sequencing:
//   A folded sample holds in_stall high through an issue state, 16 divider
//   steps and a done strobe for mean*(i-1)/i, 11 steps and a done strobe for
//   count/i, and the fold-in state, so samples go in one at a time. A round
//   result is loaded into the output register by the fold-in state and shows
//   on out_valid. Samples for idle or out-of-range fans hold in_stall for one
//   cycle. If the receiver stalls with a result still held, the next round end
//   waits in its final state until the output register frees up.
// Reset: all fans idle, means and sample numbers zero, ranges at code 2.
// ----------------------------------------------------------------------------
module fan_speed_range_autotune_top #(
	parameter int FAN_COUNT         = 6,
	parameter int SAMPLES_PER_ROUND = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  fan_index,
	input  logic [10:0] tach_value,
	input  logic        start_req,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_fan,
	output logic [2:0]  range_code,
	output logic [10:0] round_average,
	output logic [1:0]  status,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);

	localparam int IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_DIV2 = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DROP = 3'd5;

	logic [2:0] state_q;

	// per-fan state
	fsra_pkg::code_t  fan_range_q [FAN_COUNT];
	fsra_pkg::num_t   sample_q    [FAN_COUNT];
	fsra_pkg::count_t mean_q      [FAN_COUNT];
	logic             active_q    [FAN_COUNT];

	// item in work
	logic [IDX_W-1:0] fan_q;
	fsra_pkg::count_t cnt_q;
	fsra_pkg::num_t   num_q;       // i, the sample number of this sample
	fsra_pkg::count_t base_q;      // mean before this sample
	fsra_pkg::count_t q1_q;        // mean*(i-1)/i
	fsra_pkg::count_t newmean_q;

	// output register
	logic             out_valid_q;
	logic [2:0]       result_fan_q;
	fsra_pkg::code_t  range_code_q;
	fsra_pkg::count_t round_average_q;
	fsra_pkg::stat_t  status_q;

	logic             in_xfer;
	logic             fan_ok;
	logic [IDX_W-1:0] sel;
	logic             take;
	logic             out_free;
	logic             round_end;

	fsra_pkg::div_ctrl_t div_ctrl;
	fsra_pkg::div_stat_t div_stat;
	fsra_pkg::prod_t     div_dividend;
	fsra_pkg::prod_t     div_quot;
	fsra_pkg::prod_t     product;

	fsra_pkg::code_t     rule_code;
	fsra_pkg::stat_t     rule_stat;
	fsra_pkg::code_t     cfg_code;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign fan_ok    = 32'(fan_index) < FAN_COUNT;
	assign sel       = IDX_W'(fan_index);
	// the sample counts only if its fan is, or now becomes, active
	assign take      = fan_ok && (start_req || active_q[sel]);
	assign out_free  = !out_valid_q || !out_stall;
	assign round_end = num_q >= fsra_pkg::NUM_W'(SAMPLES_PER_ROUND);
	assign cfg_code  = (cfg_data > fsra_pkg::RANGE_32) ? fsra_pkg::RANGE_32 : cfg_data;

	// mean * (i - 1) at full product width feeds the divider register directly
	assign product = {{fsra_pkg::NUM_W{1'b0}}, base_q}
		* {{fsra_pkg::CNT_W{1'b0}}, num_q - 1'b1};

	// issue a divide: the product first, then the count left-aligned
	always_comb begin
		div_ctrl.start = 1'b0;
		div_ctrl.steps = fsra_pkg::STEP_W'(fsra_pkg::PROD_W);
		div_dividend   = product;
		if (state_q == S_MUL) begin
			div_ctrl.start = 1'b1;
		end else if (state_q == S_DIV1 && div_stat.done) begin
			div_ctrl.start = 1'b1;
			div_ctrl.steps = fsra_pkg::STEP_W'(fsra_pkg::CNT_W);
			div_dividend   = {cnt_q, {(fsra_pkg::PROD_W - fsra_pkg::CNT_W){1'b0}}};
		end
	end

	fsra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.divisor  (num_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	fsra_rules u_rules (
		.mean     (newmean_q),
		.code_in  (fan_range_q[fan_q]),
		.code_out (rule_code),
		.status   (rule_stat)
	);

	// sequencer and per-fan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int k = 0; k < FAN_COUNT; k++) begin
				fan_range_q[k] <= fsra_pkg::RANGE_RESET;
				sample_q[k]    <= '0;
				mean_q[k]      <= '0;
				active_q[k]    <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						for (int k = 0; k < FAN_COUNT; k++) begin
							fan_range_q[k] <= cfg_code;
						end
					end
					if (in_xfer) begin
						state_q <= take ? S_MUL : S_DROP;
					end
				end
				S_MUL: begin
					state_q <= S_DIV1;
				end
				S_DIV1: begin
					if (div_stat.done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!round_end) begin
						// fold in and wait for the next sample
						sample_q[fan_q] <= num_q;
						mean_q[fan_q]   <= newmean_q;
						active_q[fan_q] <= 1'b1;
						state_q         <= S_IDLE;
					end else if (out_free) begin
						fan_range_q[fan_q] <= rule_code;
						sample_q[fan_q]    <= '0;
						mean_q[fan_q]      <= '0;
						active_q[fan_q]    <= (rule_stat == fsra_pkg::STAT_RETRY);
						state_q            <= S_IDLE;
					end
				end
				S_DROP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fan_q <= sel;
			cnt_q <= tach_value;
			// start restarts the pass with this sample as the first
			if (start_req) begin
				num_q  <= fsra_pkg::NUM_W'(1);
				base_q <= '0;
			end else begin
				num_q  <= sample_q[sel] + 1'b1;
				base_q <= mean_q[sel];
			end
		end
		if (state_q == S_DIV1 && div_stat.done) begin
			q1_q <= div_quot[fsra_pkg::CNT_W-1:0];
		end
		if (state_q == S_DIV2 && div_stat.done) begin
			newmean_q <= q1_q + div_quot[fsra_pkg::CNT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && round_end && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && round_end && out_free) begin
			result_fan_q    <= 3'(fan_q);
			range_code_q    <= rule_code;
			round_average_q <= newmean_q;
			status_q        <= rule_stat;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_fan    = result_fan_q;
	assign range_code    = range_code_q;
	assign round_average = round_average_q;
	assign status        = status_q;

endmodule
